// ===== hdl/xee_pkg.sv =====
`timescale 1ns / 1ps

package xee_pkg;

	// longest escaped run and the width of a byte index within a run
	localparam int MaxRun = 6;
	localparam int IdxW   = $clog2(MaxRun);

	typedef logic [7:0]      char_t;
	typedef logic [IdxW-1:0] idx_t;
	typedef logic [47:0]     run_text_t;

	// markup characters that get a named entity
	localparam char_t ChQuot = 8'h22;
	localparam char_t ChAmp  = 8'h26;
	localparam char_t ChApos = 8'h27;
	localparam char_t ChLt   = 8'h3c;
	localparam char_t ChGt   = 8'h3e;
	localparam char_t ChSemi = 8'h3b;

	// entity text, left aligned, zero padded to six bytes
	localparam run_text_t TxtQuot = "&quot;";
	localparam run_text_t TxtAmp  = {"&amp;", 8'h00};
	localparam run_text_t TxtApos = "&apos;";
	localparam run_text_t TxtLt   = {"&lt;", 16'h0000};
	localparam run_text_t TxtGt   = {"&gt;", 16'h0000};

	// byte values that must go out as a numeric entity
	function automatic logic is_ctrl(input char_t c);
		logic r;
		r = (c <= 8'h08) || (c == 8'h0b) || (c == 8'h0c) ||
			((c >= 8'h0e) && (c <= 8'h1f));
		return r;
	endfunction

	// lower-case hex digit
	function automatic char_t hex_digit(input logic [3:0] n);
		char_t r;
		if (n < 4'd10) begin
			r = 8'h30 + {4'h0, n};
		end else begin
			r = 8'h57 + {4'h0, n};
		end
		return r;
	endfunction

	// number of bytes in the escaped run of a character
	function automatic idx_t run_len(input char_t c);
		idx_t r;
		unique case (c)
			ChQuot:  r = idx_t'(6);
			ChAmp:   r = idx_t'(5);
			ChApos:  r = idx_t'(6);
			ChLt:    r = idx_t'(4);
			ChGt:    r = idx_t'(4);
			default: r = is_ctrl(c) ? idx_t'(6) : idx_t'(1);
		endcase
		return r;
	endfunction

	// byte i of a six-byte text
	function automatic char_t pick(input run_text_t s, input idx_t i);
		char_t r;
		unique case (i)
			idx_t'(0): r = s[47:40];
			idx_t'(1): r = s[39:32];
			idx_t'(2): r = s[31:24];
			idx_t'(3): r = s[23:16];
			idx_t'(4): r = s[15:8];
			idx_t'(5): r = s[7:0];
			default:   r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/xee_in_if.sv =====
`timescale 1ns / 1ps

interface xee_in_if;
	import xee_pkg::*;

	logic  valid;
	logic  ready;
	char_t in_char;

	modport source (output valid, output in_char, input ready);
	modport sink (input valid, input in_char, output ready);
endinterface

// ===== hdl/xee_out_if.sv =====
`timescale 1ns / 1ps

interface xee_out_if;
	import xee_pkg::*;

	logic  valid;
	logic  ready;
	char_t out_char;
	logic  run_end;

	modport source (output valid, output out_char, output run_end, input ready);
	modport sink (input valid, input out_char, input run_end, output ready);
endinterface

// ===== hdl/xee_expand.sv =====
`timescale 1ns / 1ps

module xee_expand
	import xee_pkg::*;
(
	input  char_t chr,
	input  idx_t  idx,
	output char_t data,
	output logic  last
);

	run_text_t text;

	always_comb begin
		unique case (chr)
			ChQuot:  text = TxtQuot;
			ChAmp:   text = TxtAmp;
			ChApos:  text = TxtApos;
			ChLt:    text = TxtLt;
			ChGt:    text = TxtGt;
			default: text = {"&#x", hex_digit(chr[7:4]), hex_digit(chr[3:0]), ChSemi};
		endcase
	end

	// plain characters are a run of one byte, the character itself
	assign data = (run_len(chr) == idx_t'(1)) ? chr : pick(text, idx);
	assign last = (idx == (run_len(chr) - idx_t'(1)));

endmodule

// ===== hdl/xml_entity_escape_top.sv =====
`timescale 1ns / 1ps

// xml entity escaper
// rx: one raw character per item (in_char), valid/ready handshake
// tx: one escaped byte per item (out_char), run_end set on the last byte
//     of the run that belongs to one input character
// markup characters become named entities (4 to 6 bytes), control bytes
// become &#xHH; (6 bytes) except tab, LF and CR, every other character passes as one byte
// the first byte of a run passes through the input register and then the
//   output register before it shows on tx
// one tx item per cycle while tx.ready stays high; a character with an n-byte
//   run holds the input register until its last byte moves on, so plain text
//   moves at one character per cycle and an escaped character keeps rx.ready low for the rest of its run
// the limit is the single input register that walks the run byte by byte
// a stall on tx holds the output register; the input register then holds
//   too and rx.ready drops until the run moves on
// reset clears both valid flags; no item is lost or repeated across a stall

module xml_entity_escape_top
	import xee_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	xee_in_if.sink   rx,
	xee_out_if.source tx
);

	// input register: current character and position within its run
	char_t char_s1;
	idx_t  idx_s1;
	logic  valid_s1;

	// output register
	char_t out_char_s2;
	logic  run_end_s2;
	logic  valid_s2;

	char_t byte_c;
	logic  last_c;
	logic  advance;
	logic  rx_take;

	xee_expand u_expand (
		.chr  (char_s1),
		.idx  (idx_s1),
		.data (byte_c),
		.last (last_c)
	);

	// move one byte into the output register when it is free or draining
	assign advance = valid_s1 && (!valid_s2 || tx.ready);

	// take the next character when the input register is empty or while the last byte of this run moves on
	assign rx.ready = !valid_s1 || (advance && last_c);
	assign rx_take  = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
		end else if (rx_take) begin
			valid_s1 <= 1'b1;
			idx_s1   <= '0;
		end else if (advance) begin
			if (last_c) begin
				valid_s1 <= 1'b0;
				idx_s1   <= '0;
			end else begin
				idx_s1 <= idx_s1 + idx_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) begin
			char_s1 <= rx.in_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (tx.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_char_s2 <= byte_c;
			run_end_s2  <= last_c;
		end
	end

	assign tx.valid    = valid_s2;
	assign tx.out_char = out_char_s2;
	assign tx.run_end  = run_end_s2;

endmodule

// ===== hdl/xee_checker.sv =====
`timescale 1ns / 1ps

module xee_checker
	import xee_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  rx_valid,
	input logic  rx_ready,
	input logic  tx_valid,
	input logic  tx_ready,
	input char_t tx_out_char,
	input logic  tx_run_end
);

	// stalled output holds
	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid && $stable(tx_out_char) && $stable(tx_run_end))
		else $error("tx item changed under stall");

	// accepted character reaches tx through the input and output registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid && rx_ready |-> ##2 tx_valid)
		else $error("accepted character did not reach tx");

	// the rest of a run follows without a gap
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_ready && !tx_run_end |=> tx_valid)
		else $error("gap inside an escaped run");

	// a semicolon always closes its run
	a_semi_last: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_run_end |-> tx_out_char != ChSemi)
		else $error("semicolon not at end of run");

endmodule

bind xml_entity_escape_top xee_checker u_xee_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rx_valid    (rx.valid),
	.rx_ready    (rx.ready),
	.tx_valid    (tx.valid),
	.tx_ready    (tx.ready),
	.tx_out_char (tx.out_char),
	.tx_run_end  (tx.run_end)
);
